// ===== src/bht_pkg.sv =====
// Package for the bucketed hash table: payload structs, operation and status codes,
// default sizes and the back part's state codes. No dependencies.
package bht_pkg;

    localparam int NUM_BUCKETS_DEF  = 16;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int KEY_W   = 31;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_SPARE     = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [1:0]         operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed
    {
        logic [1:0]         status;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] bucket_count;
    } out_item_t;

    typedef enum logic [1:0]
    {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_WRITE = 2'd2
    } back_state_t;

endpackage

// ===== src/bht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== src/bht_front.sv =====
// Front part: takes items off the input port, works out the bucket and queues
// the item with its bucket in a two-entry queue for the back part. Depends on bht_pkg.
module bht_front
    import bht_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  in_item_t                       in_item,
    output logic                           cmd_valid,
    input  logic                           cmd_take,
    output in_item_t                       cmd_item,
    output logic [$clog2(NUM_BUCKETS)-1:0] cmd_bucket
);

    localparam int BW = $clog2(NUM_BUCKETS);

    in_item_t          q_item_reg [2];
    logic [BW-1:0]     q_bkt_reg  [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic [BW-1:0]     bucket;
    logic              do_push, do_pop;

    // A power-of-two bucket count takes the low key bits. Any other count uses a
    // reciprocal multiplication that is exact for every 31-bit key; only the low
    // bits of the quotient are needed to form the remainder.
    generate
        if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0)
        begin : g_pow2
            assign bucket = in_item.key[BW-1:0];
        end
        else
        begin : g_recip
            localparam int SH = KEY_W + BW;
            localparam logic [63:0] RECIP =
                ((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
            localparam logic [BW-1:0] NB_LO = BW'(NUM_BUCKETS);
            logic [63:0]   prod;
            logic [BW-1:0] quo_lo;
            assign prod   = 64'(in_item.key) * RECIP;
            assign quo_lo = prod[SH +: BW];
            assign bucket = in_item.key[BW-1:0] - BW'(quo_lo * NB_LO);
        end
    endgenerate

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_item  = q_item_reg[rp_reg];
    assign cmd_bucket = q_bkt_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_item_reg[wp_reg] <= in_item;
            q_bkt_reg[wp_reg]  <= bucket;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("front queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("front queue lost a push");
    assert property (@(posedge clk) disable iff (!rst_n) cmd_valid == (cnt_reg != 2'd0))
        else $error("front queue valid mismatch");

endmodule

// ===== src/bht_back.sv =====
// Back part: reads one bucket row, matches all slots in parallel, writes the row back
// shifted on insert or remove and registers the result. Depends on bht_pkg and bht_ram.
module bht_back
    import bht_pkg::*;
#(
    parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_take,
    input  in_item_t                       cmd_item,
    input  logic [$clog2(NUM_BUCKETS)-1:0] cmd_bucket,
    output logic                           empty,
    input  logic                           pop,
    output out_item_t                      out_item
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int PW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int ROW_W = BUCKET_DEPTH * (KEY_W + VALUE_W);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUCKET_DEPTH);

    typedef struct packed
    {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    back_state_t          state_reg, state_next;
    in_item_t             item_reg;
    logic [BW-1:0]        bkt_reg;
    logic [BW-1:0]        rd_bucket;
    logic [FW-1:0]        fill_reg [NUM_BUCKETS];
    logic [FW-1:0]        fill_r;
    slot_t [BUCKET_DEPTH-1:0] row_rd, row_wr;
    logic                 row_we;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    logic [FW-1:0]        fill_new;
    out_item_t            res;
    logic                 hit;
    logic [PW-1:0]        pos;
    logic                 res_ok;

    bht_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (bkt_reg),
        .wdata (row_wr),
        .raddr (rd_bucket),
        .rdata (row_rd)
    );

    // While an item waits on the output, keep reading its own row so the data holds.
    assign rd_bucket = (state_reg == BK_IDLE) ? cmd_bucket : bkt_reg;
    assign fill_r   = fill_reg[bkt_reg];
    // A result can be staged when the output register is free or being drained.
    assign res_ok   = !out_valid_reg || pop;
    assign cmd_take = (state_reg == BK_IDLE) && cmd_valid;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (cmd_valid) state_next = BK_READ;
            BK_READ:  if (res_ok) state_next = BK_IDLE;
            BK_WRITE: state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Parallel match over the live slots; the lowest index is the newest entry.
    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = BUCKET_DEPTH - 1; i >= 0; i--)
        begin
            if (FW'(i) < fill_r && row_rd[i].key == item_reg.key)
            begin
                hit = 1'b1;
                pos = PW'(i);
            end
        end
    end

    always_comb
    begin
        row_wr   = row_rd;
        row_we   = 1'b0;
        fill_new = fill_r;
        res.status       = ST_OK;
        res.found_value  = '0;
        case (op_t'(item_reg.operation))
            OP_INSERT:
            begin
                if (fill_r >= DEPTH_F)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = 1; i < BUCKET_DEPTH; i++)
                    begin
                        row_wr[i] = row_rd[i-1];
                    end
                    row_wr[0].key   = item_reg.key;
                    row_wr[0].value = item_reg.value;
                    row_we   = 1'b1;
                    fill_new = fill_r + FW'(1);
                end
            end
            OP_REMOVE, OP_SEARCH:
            begin
                if (!hit)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    res.found_value = row_rd[pos].value;
                    if (item_reg.operation == OP_REMOVE)
                    begin
                        for (int i = 0; i < BUCKET_DEPTH - 1; i++)
                        begin
                            if (FW'(i) >= FW'(pos))
                            begin
                                row_wr[i] = row_rd[i+1];
                            end
                        end
                        row_we   = 1'b1;
                        fill_new = fill_r - FW'(1);
                    end
                end
            end
            default: ;
        endcase
        row_we = row_we && (state_reg == BK_READ) && res_ok;
        res.bucket_count = COUNT_W'(fill_new);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            item_reg <= cmd_item;
            bkt_reg  <= cmd_bucket;
        end
        if (state_reg == BK_READ && res_ok)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_READ && res_ok)
            begin
                out_valid_reg <= 1'b1;
                fill_reg[bkt_reg] <= fill_new;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> fill_r <= DEPTH_F)
        else $error("bucket fill beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ && res_ok) |=> out_valid_reg)
        else $error("finished item left no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (state_reg == BK_READ))
        else $error("row written outside the update cycle");

endmodule

// ===== src/bucketed_hash_table.sv =====
// Bucketed hash table: one insert, remove or search per item, one result each.
// An item passes the front queue, the back part's read state and the result register,
// waiting while the output stalls; the back part reads its row and writes it back if
// changed before it takes the next item. The row memory holds one bucket per word;
// all slots match in parallel. Reset clears the queue, the result valid flag and every
// bucket fill at once; slots need no clearing as only those below the fill are read.
module bucketed_hash_table
    import bht_pkg::*;
#(
    parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic                           cmd_valid, cmd_take;
    in_item_t                       cmd_item;
    logic [$clog2(NUM_BUCKETS)-1:0] cmd_bucket;

    bht_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd_item   (cmd_item),
        .cmd_bucket (cmd_bucket)
    );

    bht_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd_item   (cmd_item),
        .cmd_bucket (cmd_bucket),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule

// ===== test/tb.sv =====
// Testbench for the bucketed hash table: directed and random insert, remove and search
// transfers checked against a behavioural table kept here. Depends on bht_pkg and the RTL.
module tb;
    import bht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = NUM_BUCKETS_DEF;
    localparam int BD = BUCKET_DEPTH_DEF;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    bucketed_hash_table u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // Behavioural copy of the table.
    logic [KEY_W-1:0]   tbl_keys   [NB][BD];
    logic [VALUE_W-1:0] tbl_values [NB][BD];
    int                 tbl_fill   [NB];

    in_item_t  pending_ops[$];
    out_item_t expected_replies[$];

    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 0;
    int  hold_off = 0;
    bit  hold_started = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic out_item_t apply_op(in_item_t it);
        out_item_t  r;
        int         b;
        int         pos;
        b = it.key % NB;
        pos = -1;
        r = '0;
        case (op_t'(it.operation))
            OP_INSERT:
            begin
                if (tbl_fill[b] >= BD)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = tbl_fill[b]; i > 0; i--)
                    begin
                        tbl_keys[b][i]   = tbl_keys[b][i-1];
                        tbl_values[b][i] = tbl_values[b][i-1];
                    end
                    tbl_keys[b][0]   = it.key;
                    tbl_values[b][0] = it.value;
                    tbl_fill[b]++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE, OP_SEARCH:
            begin
                for (int i = 0; i < tbl_fill[b]; i++)
                begin
                    if (pos < 0 && tbl_keys[b][i] == it.key)
                    begin
                        pos = i;
                    end
                end
                if (pos < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    r.status = ST_OK;
                    r.found_value = tbl_values[b][pos];
                    if (op_t'(it.operation) == OP_REMOVE)
                    begin
                        for (int i = pos; i + 1 < tbl_fill[b]; i++)
                        begin
                            tbl_keys[b][i]   = tbl_keys[b][i+1];
                            tbl_values[b][i] = tbl_values[b][i+1];
                        end
                        tbl_fill[b]--;
                    end
                end
            end
            default:
            begin
                r.status = ST_OK;
            end
        endcase
        r.bucket_count = COUNT_W'(tbl_fill[b]);
        return r;
    endfunction

    function automatic in_item_t make_op(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
        in_item_t it;
        it.operation = op;
        it.key = k;
        it.value = v;
        return it;
    endfunction

    // Idling is switched off between cycle 400 and 1200, giving a clean stretch.
    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 6);
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_replies.push_back(apply_op(in_item));
            end
            if ((!push || !full))
            begin
                if (pending_ops.size() > 0 && !take_gap())
                begin
                    push <= 1'b1;
                    in_item <= pending_ops.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            cycles++;
            if (pop && !empty)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_item);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_replies.pop_front();
                    if (out_item.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, out_item.status);
                        errors++;
                    end
                    if (out_item.found_value !== e.found_value)
                    begin
                        $display("%0t: found_value expected %h actual %h",
                                 $time, e.found_value, out_item.found_value);
                        errors++;
                    end
                    if (out_item.bucket_count !== e.bucket_count)
                    begin
                        $display("%0t: bucket_count expected %0d actual %0d",
                                 $time, e.bucket_count, out_item.bucket_count);
                        errors++;
                    end
                end
            end
            quiet <= (cycles > 400 && cycles < 1200);
            // One long hold-off while the sender keeps offering transfers.
            if (!hold_started && cycles == 1500)
            begin
                hold_started <= 1'b1;
                hold_off <= 200;
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !take_gap();
            end
            if (cycles > 200000)
            begin
                $display("[bucketed_hash_table] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key(int b);
        // Small key pool per bucket so duplicates and hits are common.
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0:       k = KEY_W'($urandom);
            default: k = KEY_W'($urandom_range(5) * NB + b);
        endcase
        if ($urandom_range(19) == 0)
        begin
            k = {KEY_W{1'b1}} - KEY_W'($urandom_range(NB - 1));
        end
        return k;
    endfunction

    initial
    begin
        int b;
        logic [KEY_W-1:0] k;
        rst_n = 1'b0;
        for (int i = 0; i < NB; i++)
        begin
            tbl_fill[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty search and remove, extremes, duplicates, bucket full, spare code.
        pending_ops.push_back(make_op(OP_SEARCH, 31'd0, 32'd0));
        pending_ops.push_back(make_op(OP_REMOVE, 31'd5, 32'd0));
        pending_ops.push_back(make_op(OP_INSERT, {KEY_W{1'b1}}, 32'h8000_0000));
        pending_ops.push_back(make_op(OP_SEARCH, {KEY_W{1'b1}}, 32'd0));
        pending_ops.push_back(make_op(OP_INSERT, 31'd0, 32'h7fff_ffff));
        pending_ops.push_back(make_op(OP_INSERT, 31'd0, 32'hffff_ffff));
        pending_ops.push_back(make_op(OP_SEARCH, 31'd0, 32'd0));
        for (int i = 1; i <= BD; i++)
        begin
            pending_ops.push_back(make_op(OP_INSERT, KEY_W'(i * NB + 3), 32'(i)));
        end
        pending_ops.push_back(make_op(OP_INSERT, 31'd3, 32'd99));
        pending_ops.push_back(make_op(OP_NONE, 31'd19, 32'd7));
        pending_ops.push_back(make_op(OP_REMOVE, KEY_W'(4 * NB + 3), 32'd0));
        pending_ops.push_back(make_op(OP_SEARCH, KEY_W'(4 * NB + 3), 32'd0));
        pending_ops.push_back(make_op(OP_REMOVE, 31'd0, 32'd0));
        pending_ops.push_back(make_op(OP_SEARCH, 31'd0, 32'd0));
        pending_ops.push_back(make_op(OP_REMOVE, KEY_W'(BD * NB + 3), 32'd0));

        for (int n = 0; n < 1030; n++)
        begin
            b = $urandom_range(NB - 1);
            k = rand_key(b);
            case ($urandom_range(19))
                0:                  pending_ops.push_back(make_op(OP_NONE, k, $urandom));
                1,2,3,4,5,6,7,8:    pending_ops.push_back(make_op(OP_INSERT, k, $urandom));
                9,10,11,12,13:      pending_ops.push_back(make_op(OP_REMOVE, k, $urandom));
                default:            pending_ops.push_back(make_op(OP_SEARCH, k, $urandom));
            endcase
        end

        wait (pending_ops.size() == 0 && !push);
        wait (expected_replies.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
        begin
            $display("[bucketed_hash_table] OK");
        end
        else
        begin
            $display("[bucketed_hash_table] ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/bht_pkg.sv
src/bht_ram.sv
src/bht_front.sv
src/bht_back.sv
src/bucketed_hash_table.sv
test/tb.sv
